// ----- design/double_ended_queue_defines.svh -----
// Assertion macros shared by the deque modules.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DEQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/deq_pkg.sv -----
// Shared types and constants of the double-ended queue.
package deq_pkg;

    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_REAR  = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } deq_ctrl_t;

endpackage

// ----- design/deq_ctrl.sv -----
// Controller state machine: accept a word, run it through the datapath, present the result.
`include "double_ended_queue_defines.svh"

module deq_ctrl
    import deq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output deq_ctrl_t ctrl
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall    = (state_reg != S_IDLE);
    assign rsp_valid    = (state_reg == S_RESP);
    assign ctrl.capture = (state_reg == S_IDLE) && req_valid;
    assign ctrl.execute = (state_reg == S_EXEC);

    `DEQ_ASSERT_NEXT(a_capture_then_exec, ctrl.capture, ctrl.execute, "capture not followed by execute")
    `DEQ_ASSERT_NEXT(a_exec_then_resp, ctrl.execute, rsp_valid && req_stall, "execute not followed by result")

endmodule

// ----- design/deq_datapath.sv -----
// Datapath: ring store, front pointer, fill count and result registers.
`include "double_ended_queue_defines.svh"

module deq_datapath
    import deq_pkg::*;
#(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  deq_ctrl_t                 ctrl,
    input  logic        [CMD_W-1:0]   cmd,
    input  logic signed [VALUE_W-1:0] value_in,
    output logic signed [VALUE_W-1:0] value_out,
    output logic        [STATUS_W-1:0] status,
    output logic        [OCC_W-1:0]   occupancy,
    output logic                      is_empty,
    output logic                      is_full
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [WORD_BITS-1:0] mem [CAPACITY];

    logic [CMD_W-1:0]     cmd_reg;
    logic [WORD_BITS-1:0] wdata_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 val_ok_reg;
    status_t              status_reg;
    logic [PTR_W-1:0]     head_reg;
    logic [PTR_W-1:0]     head_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    logic                 empty;
    logic                 full;
    logic [PTR_W-1:0]     head_inc;
    logic [PTR_W-1:0]     head_dec;
    logic [SUM_W-1:0]     tail_sum;
    logic [SUM_W-1:0]     rear_sum;
    logic [PTR_W-1:0]     tail_idx;
    logic [PTR_W-1:0]     rear_idx;
    logic [PTR_W-1:0]     mem_addr;
    logic                 mem_we;
    logic                 mem_re;
    status_t              status_next;
    logic [63:0]          win_ext;
    logic [63:0]          rd_ext;
    logic [31:0]          occ_ext;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(CAPACITY));

    assign head_inc = (head_reg == PTR_W'(CAPACITY - 1)) ? '0 : head_reg + PTR_W'(1);
    assign head_dec = (head_reg == '0) ? PTR_W'(CAPACITY - 1) : head_reg - PTR_W'(1);

    // Wrap head + count (push rear) and head + count - 1 (rear word) into the ring.
    always_comb
    begin
        tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
        if (tail_sum >= SUM_W'(CAPACITY))
        begin
            tail_sum = tail_sum - SUM_W'(CAPACITY);
        end
        rear_sum = SUM_W'(head_reg) + SUM_W'(count_reg) - SUM_W'(1);
        if (rear_sum >= SUM_W'(CAPACITY))
        begin
            rear_sum = rear_sum - SUM_W'(CAPACITY);
        end
    end

    assign tail_idx = tail_sum[PTR_W-1:0];
    assign rear_idx = rear_sum[PTR_W-1:0];

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        mem_addr    = head_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        status_next = ST_OK;
        case (cmd_reg)
            CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    mem_addr   = head_dec;
                    mem_we     = 1'b1;
                    head_next  = head_dec;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_PUSH_REAR:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    mem_addr   = tail_idx;
                    mem_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_POP_FRONT, CMD_PEEK_FRONT:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    mem_addr = head_reg;
                    mem_re   = 1'b1;
                    if (cmd_reg == CMD_POP_FRONT)
                    begin
                        head_next  = head_inc;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            CMD_POP_REAR, CMD_PEEK_REAR:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    mem_addr = rear_idx;
                    mem_re   = 1'b1;
                    if (cmd_reg == CMD_POP_REAR)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign win_ext = {32'b0, value_in};

    // Hold the accepted word until execute.
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg   <= cmd;
            wdata_reg <= win_ext[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.execute && mem_we)
        begin
            mem[mem_addr] <= wdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.execute && mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.execute)
        begin
            val_ok_reg <= mem_re;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (ctrl.execute)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    assign rd_ext    = 64'(rd_data_reg);
    assign occ_ext   = 32'(count_reg);
    assign value_out = val_ok_reg ? rd_ext[VALUE_W-1:0] : '0;
    assign status    = status_reg;
    assign occupancy = occ_ext[OCC_W-1:0];
    assign is_empty  = empty;
    assign is_full   = full;

    `DEQ_ASSERT_NOW(a_count_in_range, 1'b1, count_reg <= CNT_W'(CAPACITY), "fill count above capacity")
    `DEQ_ASSERT_NEXT(a_push_grows, ctrl.execute && mem_we, count_reg == $past(count_reg) + CNT_W'(1), "push did not grow fill count")

endmodule

// ----- design/double_ended_queue.sv -----
// Top level of the bounded double-ended queue.
//
//  channel   valid      stall      payload
//  request   req_valid  req_stall  cmd, value_in
//  response  rsp_valid  rsp_stall  value_out, status, occupancy, is_empty, is_full
//
// A word passes through capture, one ring store access with registered read data,
// and the result stage, in that order; the result is offered after the execute step.
// req_stall is high from acceptance until the result is taken,
// so one word is in flight at a time.
// rsp_stall holds the result and the request side stays stalled meanwhile.
// Reset clears the front pointer and fill count; the ring store has no reset.
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  logic        [CMD_W-1:0]    cmd,
    input  logic signed [VALUE_W-1:0]  value_in,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output logic signed [VALUE_W-1:0]  value_out,
    output logic        [STATUS_W-1:0] status,
    output logic        [OCC_W-1:0]    occupancy,
    output logic                       is_empty,
    output logic                       is_full
);

    deq_ctrl_t ctrl;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctrl      (ctrl)
    );

    deq_datapath #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cmd       (cmd),
        .value_in  (value_in),
        .value_out (value_out),
        .status    (status),
        .occupancy (occupancy),
        .is_empty  (is_empty),
        .is_full   (is_full)
    );

endmodule

// ----- sim/tb_double_ended_queue.sv -----
// Testbench for the double-ended queue: directed and random commands checked against a predictor.
module tb_double_ended_queue;
    import deq_pkg::*;

    localparam int DEPTH = 16;
    localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;
    localparam int RANDOM_PHASES = 19;
    localparam int PHASE_WORDS = 100;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        status_t                   code;
        logic [OCC_W-1:0]          occ;
        logic                      empty;
        logic                      full;
    } deque_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       req_valid = 1'b0;
    logic                       req_stall;
    logic        [CMD_W-1:0]    cmd = '0;
    logic signed [VALUE_W-1:0]  value_in = '0;
    logic                       rsp_valid;
    logic                       rsp_stall = 1'b0;
    logic signed [VALUE_W-1:0]  value_out;
    logic        [STATUS_W-1:0] status;
    logic        [OCC_W-1:0]    occupancy;
    logic                       is_empty;
    logic                       is_full;

    // Predictor state
    logic signed [VALUE_W-1:0] model_ring [DEPTH];
    int                        model_head = 0;
    int                        model_fill = 0;

    deque_result_t pending_results [$];
    int            mismatches = 0;
    int            hold_cycles = 0;
    bit            quiet = 1'b0;

    double_ended_queue DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .value_in  (value_in),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .value_out (value_out),
        .status    (status),
        .occupancy (occupancy),
        .is_empty  (is_empty),
        .is_full   (is_full)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Work out the result of one accepted command and queue it.
    task automatic apply_command(input logic [CMD_W-1:0] c, input logic signed [VALUE_W-1:0] v);
        deque_result_t r;
        int            pos;
        r.value = '0;
        r.code  = ST_OK;
        case (c)
            CMD_PUSH_FRONT, CMD_PUSH_REAR:
            begin
                if (model_fill >= DEPTH)
                    r.code = ST_FULL;
                else if (c == CMD_PUSH_FRONT)
                begin
                    model_head = (model_head + DEPTH - 1) % DEPTH;
                    model_ring[model_head] = v;
                    model_fill++;
                end
                else
                begin
                    model_ring[(model_head + model_fill) % DEPTH] = v;
                    model_fill++;
                end
            end
            CMD_POP_FRONT, CMD_PEEK_FRONT:
            begin
                if (model_fill == 0)
                    r.code = ST_EMPTY;
                else
                begin
                    r.value = model_ring[model_head];
                    if (c == CMD_POP_FRONT)
                    begin
                        model_head = (model_head + 1) % DEPTH;
                        model_fill--;
                    end
                end
            end
            CMD_POP_REAR, CMD_PEEK_REAR:
            begin
                if (model_fill == 0)
                    r.code = ST_EMPTY;
                else
                begin
                    pos = (model_head + model_fill - 1) % DEPTH;
                    r.value = model_ring[pos];
                    if (c == CMD_POP_REAR)
                        model_fill--;
                end
            end
            default:
            begin
            end
        endcase
        r.occ   = model_fill[OCC_W-1:0];
        r.empty = (model_fill == 0);
        r.full  = (model_fill >= DEPTH);
        pending_results.push_back(r);
    endtask

    // Offer one word after a random gap (none when quiet) and hold it until accepted.
    task automatic send_word(input logic [CMD_W-1:0] c, input logic signed [VALUE_W-1:0] v);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        cmd       <= c;
        value_in  <= v;
        do
            @(posedge clk);
        while (req_stall);
        apply_command(c, v);
    endtask

    // Drop valid and wait until every queued result has come back.
    task automatic drain_results();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(input int push_pct);
        int  r;
        bit  rear;
        r    = $urandom_range(0, 99);
        rear = $urandom_range(0, 1);
        if (r < 3)
            return rear ? CMD_RSVD_7 : CMD_RSVD_6;
        if (r < 3 + push_pct)
            return rear ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
        if ($urandom_range(0, 9) < 7)
            return rear ? CMD_POP_REAR : CMD_POP_FRONT;
        return rear ? CMD_PEEK_REAR : CMD_PEEK_FRONT;
    endfunction

    task automatic check_field(input string name, input logic [VALUE_W-1:0] exp_val,
                               input logic [VALUE_W-1:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                     act_val);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        deque_result_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, actual value %0h status %0d", $time,
                         value_out, status);
                mismatches++;
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("value_out", e.value, value_out);
                check_field("status", e.code, status);
                check_field("occupancy", e.occ, occupancy);
                check_field("is_empty", e.empty, is_empty);
                check_field("is_full", e.full, is_full);
            end
        end
    end

    // Receiver stalls: a requested long hold, else, unless quiet, a short random stall after each word.
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
                rsp_stall <= 1'b0;
            end
            else if (rsp_valid && !rsp_stall && !quiet)
            begin
                n = $urandom_range(0, 3);
                if (n > 0)
                begin
                    rsp_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                    rsp_stall <= 1'b0;
                end
            end
        end
    end

    task automatic test_empty_deque();
        send_word(CMD_POP_FRONT, pick_value());
        send_word(CMD_POP_REAR, pick_value());
        send_word(CMD_PEEK_FRONT, pick_value());
        send_word(CMD_PEEK_REAR, pick_value());
        send_word(CMD_RSVD_6, pick_value());
        send_word(CMD_RSVD_7, pick_value());
    endtask

    task automatic test_fill_and_overflow();
        logic signed [VALUE_W-1:0] extremes [4];
        logic signed [VALUE_W-1:0] v;
        extremes = '{32'sh8000_0000, 32'sh7fff_ffff, -32'sd1, 32'sd0};
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i < 4)
                v = extremes[i];
            else
                v = (i % 4 < 2 ? 32'sh5555_5555 : 32'shAAAA_AAAA) ^ i;
            send_word(i % 2 ? CMD_PUSH_REAR : CMD_PUSH_FRONT, v);
        end
        // full now: both pushes must be dropped
        send_word(CMD_PUSH_FRONT, pick_value());
        send_word(CMD_PUSH_REAR, pick_value());
        send_word(CMD_PEEK_FRONT, pick_value());
        send_word(CMD_PEEK_REAR, pick_value());
        send_word(CMD_RSVD_7, pick_value());
        send_word(CMD_POP_FRONT, pick_value());
        send_word(CMD_POP_REAR, pick_value());
    endtask

    task automatic test_receiver_hold();
        hold_cycles = 60;
        for (int i = 0; i < 10; i++)
            send_word(pick_command(50), pick_value());
    endtask

    task automatic test_sender_pause();
        for (int i = 0; i < 20; i++)
            send_word(pick_command(50), pick_value());
        drain_results();
        for (int i = 0; i < 10; i++)
            send_word(pick_command(50), pick_value());
    endtask

    task automatic test_random_traffic();
        int push_pct [5];
        push_pct = '{80, 30, 55, 65, 40};
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            quiet = (phase % 4 == 3);
            if (phase == 9)
                drain_results();
            for (int i = 0; i < PHASE_WORDS; i++)
                send_word(pick_command(push_pct[phase % 5]), pick_value());
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        int waited;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_deque();
        test_fill_and_overflow();
        test_receiver_hold();
        test_sender_pause();
        test_random_traffic();
        req_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
